/* hdl/strained_anchor_nearest_search_macros.svh */
// assertion macros for the strained anchor nearest search block
`ifndef STRAINED_ANCHOR_NEAREST_SEARCH_MACROS_SVH
`define STRAINED_ANCHOR_NEAREST_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SANS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sans assertion failed");
// next-cycle implication
`define SANS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sans assertion failed");
`else
`define SANS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SANS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sans_pkg.sv */
// shared types, constants and arithmetic helpers for the anchor search
package sans_pkg;

    localparam int MAX_ANCHORS_DEF = 128;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 52;
    localparam int PROD_W  = 64;
    localparam int DIST_W  = 63;
    localparam int KIND_W  = 3;
    localparam int IDX_O_W = 7;
    localparam int IN_W    = 3 * DATA_W;
    localparam int OUT_W   = 168;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // item kinds
    localparam logic [KIND_W-1:0] CMD_AGENT  = 3'd0;
    localparam logic [KIND_W-1:0] CMD_CENTRE = 3'd1;
    localparam logic [KIND_W-1:0] CMD_DIAG   = 3'd2;
    localparam logic [KIND_W-1:0] CMD_SHEAR  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_RADIUS = 3'd4;
    localparam logic [KIND_W-1:0] CMD_ANCHOR = 3'd5;

    // multiplier operand selects
    localparam logic [2:0] MS_T0  = 3'd0;
    localparam logic [2:0] MS_T1  = 3'd1;
    localparam logic [2:0] MS_T2  = 3'd2;
    localparam logic [2:0] MS_RAD = 3'd3;
    localparam logic [2:0] MS_SQ  = 3'd4;

    // strain term slot for row i, column j (xx yy zz xy xz yz)
    localparam logic [2:0] E_MAP [3][3] = '{
        '{3'd0, 3'd3, 3'd4},
        '{3'd3, 3'd1, 3'd5},
        '{3'd4, 3'd5, 3'd2}
    };

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_init;
        logic       acc_add;
        logic       du_en;
        logic       w_en;
        logic       diff_en;
        logic       sum1_en;
        logic       sum2_en;
        logic       upd_en;
        logic       emit_en;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
    } t_dp_stat;

    // q16.16 product rounding, half toward plus infinity
    function automatic logic signed [47:0] rnd_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + 64'sd32768;
        return t[PROD_W-1:16];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
            r = 32'sh7fffffff;
        end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] sq_sat(input logic [PROD_W-1:0] s);
        return s[PROD_W-1] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

/* hdl/sans_dp.sv */
// datapath: loaded operands, three multiplier lanes, distance sum and best tracking
module sans_dp #(
    parameter int MAX_ANCHORS = sans_pkg::MAX_ANCHORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sans_pkg::t_dp_cmd             i_cmd,
    input  logic [sans_pkg::KIND_W-1:0]   i_kind,
    input  logic [sans_pkg::IN_W-1:0]     i_data,
    output sans_pkg::t_dp_stat            o_stat,
    output logic [sans_pkg::OUT_W-1:0]    o_result
);
    import sans_pkg::*;

    localparam int CNT_W = $clog2(MAX_ANCHORS + 1);
    localparam int IDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    logic signed [DATA_W-1:0] in_v [3];

    logic signed [DATA_W-1:0] r_agent  [3];
    logic signed [DATA_W-1:0] r_centre [3];
    logic signed [DATA_W-1:0] r_strain [6];
    logic signed [DATA_W-1:0] r_radius;
    logic signed [DATA_W-1:0] r_u      [3];

    logic signed [ACC_W-1:0]  r_acc    [3];
    logic        [PROD_W-1:0] r_prod   [3];
    logic signed [DATA_W-1:0] r_du     [3];
    logic signed [DATA_W-1:0] r_w      [3];
    logic signed [DATA_W:0]   r_diff   [3];
    logic        [DIST_W-1:0] r_sum;
    logic        [DIST_W-1:0] r_dist;

    logic        [CNT_W-1:0]  r_count;
    logic        [DIST_W-1:0] r_min_dist;
    logic        [IDX_W-1:0]  r_min_index;
    logic signed [DATA_W-1:0] r_min_pt [3];
    logic        [OUT_W-1:0]  r_out;

    logic signed [DATA_W:0]       opa [3];
    logic signed [DATA_W:0]       opb [3];
    logic signed [2*DATA_W+1:0]   mul_full [3];
    logic signed [ACC_W-1:0]      prod_rnd [3];
    logic        [IDX_W+IDX_O_W-1:0] idx_ext;
    logic                         better;

    assign in_v[0] = i_data[DATA_W-1:0];
    assign in_v[1] = i_data[2*DATA_W-1:DATA_W];
    assign in_v[2] = i_data[3*DATA_W-1:2*DATA_W];

    // lane operand selection and multiply
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (i_cmd.mul_sel)
                MS_T0: begin
                    opa[i] = 33'(r_strain[E_MAP[i][0]]);
                    opb[i] = 33'(r_u[0]);
                end
                MS_T1: begin
                    opa[i] = 33'(r_strain[E_MAP[i][1]]);
                    opb[i] = 33'(r_u[1]);
                end
                MS_T2: begin
                    opa[i] = 33'(r_strain[E_MAP[i][2]]);
                    opb[i] = 33'(r_u[2]);
                end
                MS_RAD: begin
                    opa[i] = 33'(r_radius);
                    opb[i] = 33'(r_du[i]);
                end
                MS_SQ: begin
                    opa[i] = r_diff[i];
                    opb[i] = r_diff[i];
                end
                default: begin
                    opa[i] = '0;
                    opb[i] = '0;
                end
            endcase
            mul_full[i] = opa[i] * opb[i];
            prod_rnd[i] = ACC_W'(rnd_q16(signed'(r_prod[i])));
        end
    end

    assign better = (r_count == '0) || (r_dist < r_min_dist);

    // loaded operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_agent[i]  <= '0;
                r_centre[i] <= '0;
            end
            for (int k = 0; k < 6; k++) begin
                r_strain[k] <= '0;
            end
            r_radius <= '0;
        end else if (i_cmd.load) begin
            unique case (i_kind)
                CMD_AGENT:  for (int i = 0; i < 3; i++) r_agent[i] <= in_v[i];
                CMD_CENTRE: for (int i = 0; i < 3; i++) r_centre[i] <= in_v[i];
                CMD_DIAG:   for (int i = 0; i < 3; i++) r_strain[i] <= in_v[i];
                CMD_SHEAR:  for (int i = 0; i < 3; i++) r_strain[i+3] <= in_v[i];
                CMD_RADIUS: r_radius <= in_v[0];
                default: begin
                end
            endcase
        end
    end

    // per-anchor working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_kind == CMD_ANCHOR)) begin
            for (int i = 0; i < 3; i++) r_u[i] <= in_v[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.mul_en) begin
                r_prod[i] <= mul_full[i][PROD_W-1:0];
            end
            if (i_cmd.acc_init) begin
                r_acc[i] <= ACC_W'(r_u[i]);
            end else if (i_cmd.acc_add) begin
                r_acc[i] <= r_acc[i] + prod_rnd[i];
            end
            if (i_cmd.du_en) begin
                r_du[i] <= sat32(r_acc[i] + prod_rnd[i]);
            end
            if (i_cmd.w_en) begin
                r_w[i] <= sat32(ACC_W'(r_centre[i]) + prod_rnd[i]);
            end
            if (i_cmd.diff_en) begin
                r_diff[i] <= 33'(r_w[i]) - 33'(r_agent[i]);
            end
        end
        if (i_cmd.sum1_en) begin
            r_sum <= add_sat(sq_sat(r_prod[0]), sq_sat(r_prod[1]));
        end
        if (i_cmd.sum2_en) begin
            r_dist <= add_sat(r_sum, sq_sat(r_prod[2]));
        end
    end

    // best-so-far tracking, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_en) begin
            r_count     <= '0;
            r_min_dist  <= DIST_MAX;
            r_min_index <= '0;
            for (int i = 0; i < 3; i++) r_min_pt[i] <= '0;
        end else if (i_cmd.upd_en) begin
            if (better) begin
                r_min_dist  <= r_dist;
                r_min_index <= r_count[IDX_W-1:0];
                for (int i = 0; i < 3; i++) r_min_pt[i] <= r_w[i];
            end
            r_count <= r_count + 1'b1;
        end
    end

    assign idx_ext = (IDX_W + IDX_O_W)'(r_min_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_en) begin
            r_out <= {2'b00, r_min_dist, r_min_pt[2], r_min_pt[1], r_min_pt[0],
                      idx_ext[IDX_O_W-1:0]};
        end
    end

    assign o_stat.full = (r_count == CNT_W'(MAX_ANCHORS));
    assign o_result    = r_out;

endmodule

/* hdl/sans_ctrl.sv */
// controller: item intake, per-anchor step sequence and output register valid
module sans_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sans_pkg::KIND_W-1:0] i_kind,
    input  logic                        i_last,
    input  sans_pkg::t_dp_stat          i_stat,
    input  logic                        i_out_ready,
    output logic                        o_ready,
    output logic                        o_out_valid,
    output sans_pkg::t_dp_cmd           o_cmd
);
    import sans_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_A3   = 4'd4;
    localparam logic [3:0] S_MR   = 4'd5;
    localparam logic [3:0] S_W    = 4'd6;
    localparam logic [3:0] S_DF   = 4'd7;
    localparam logic [3:0] S_SQ   = 4'd8;
    localparam logic [3:0] S_S1   = 4'd9;
    localparam logic [3:0] S_S2   = 4'd10;
    localparam logic [3:0] S_UPD  = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.load = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == CMD_ANCHOR)) begin
                    n_last = i_last;
                    if (!i_stat.full) begin
                        n_state = S_M0;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_M0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_T0;
                o_cmd.acc_init = 1'b1;
                n_state        = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T1;
                o_cmd.acc_add = 1'b1;
                n_state       = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T2;
                o_cmd.acc_add = 1'b1;
                n_state       = S_A3;
            end
            S_A3: begin
                o_cmd.du_en = 1'b1;
                n_state     = S_MR;
            end
            S_MR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_RAD;
                n_state       = S_W;
            end
            S_W: begin
                o_cmd.w_en = 1'b1;
                n_state    = S_DF;
            end
            S_DF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_SQ;
                n_state       = S_S1;
            end
            S_S1: begin
                o_cmd.sum1_en = 1'b1;
                n_state       = S_S2;
            end
            S_S2: begin
                o_cmd.sum2_en = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_en = 1'b1;
                n_state      = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit_en = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit_en) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hdl/strained_anchor_nearest_search.sv */
// top level of the strained anchor nearest search block
//
// usage: one input stream carries loads and anchors. tuser holds the kind
// (agent point, centre, diagonal strain, shear strain, radius, anchor),
// tdata the three q16.16 operands and tlast the final-anchor mark.
// loads are taken without closing the intake and held until overwritten.
// each anchor in range runs a step sequence: the three lane multipliers run the
// three strain products, then the radius product, then the squares, with
// rounding and saturation between, then the distance sum and nearest compare.
// the anchor marked last returns one result item on the output stream:
// index, world point and q32.32 squared distance of the first nearest anchor.
// it is registered in the emit step after that anchor's step sequence, or
// after its intake when the anchor count is already full; then the search
// starts afresh. a waiting result does not block further items; only a
// second result waits in its emit step until the receiver has taken the first.
// synchronous active-low reset zeroes all loaded values, clears the search
// and drops the output valid; no clearing pass is needed.
`include "strained_anchor_nearest_search_macros.svh"

module strained_anchor_nearest_search #(
    parameter int MAX_ANCHORS = sans_pkg::MAX_ANCHORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sans_pkg::IN_W-1:0]     s_axis_tdata,   // val_a, val_b, val_c
    input  logic [sans_pkg::KIND_W-1:0]   s_axis_tuser,   // cmd
    input  logic                          s_axis_tlast,   // last_anchor
    // result item stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sans_pkg::OUT_W-1:0]    m_axis_tdata    // best_index, best_x, best_y,
                                                          // best_z, best_dist_sq, zero pad
);
    import sans_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: intake, anchor step sequence, result valid
    sans_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_stat      (dp_stat),
        .i_out_ready (m_axis_tready),
        .o_ready     (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (dp_cmd)
    );

    // arithmetic lanes and nearest-anchor state
    sans_dp #(
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_kind   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_stat   (dp_stat),
        .o_result (m_axis_tdata)
    );

    // no result is written while the intake is open
    `SANS_ASSERT_SAME(a_no_emit_when_idle, i_clk, i_rst_n, s_axis_tready, !dp_cmd.emit_en)
    // a result only overwrites a free or departing output register
    `SANS_ASSERT_SAME(a_emit_slot_free, i_clk, i_rst_n, dp_cmd.emit_en,
                      !m_axis_tvalid || m_axis_tready)
    // an anchor in range closes the intake for its computation
    `SANS_ASSERT_NEXT(a_anchor_busy, i_clk, i_rst_n,
                      s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ANCHOR)
                      && !dp_stat.full, !s_axis_tready)
    // loads and unused kinds keep the intake open
    `SANS_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n,
                      s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_ANCHOR),
                      s_axis_tready)

endmodule
